// File: rtl/dq_pkg.sv
// Shared types and codes for the double-ended queue.
package dq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int FUNC_W    = 3;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_DUMP       = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_t;

  // Broadcast command to every cell for one cycle.
  typedef struct packed {
    logic              push_front;
    logic              push_back;
    logic              pop_front;
    logic              rotate;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

// File: rtl/dq_cell.sv
// One storage cell of the shifting queue row.
module dq_cell #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int IDX   = 0,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  dq_pkg::cell_cmd_t         cmd,
  input  logic [CNT_W-1:0]          count,
  input  logic [dq_pkg::DATA_W-1:0] left_data,
  input  logic [dq_pkg::DATA_W-1:0] right_data,
  input  logic [dq_pkg::DATA_W-1:0] wrap_data,
  output logic [dq_pkg::DATA_W-1:0] data
);
  import dq_pkg::*;

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [DATA_W-1:0] data_next;
  logic [CNT_W-1:0]  count_m1;

  assign count_m1 = count - CNT_W'(1);

  always_comb begin
    data_next = data;
    if (cmd.push_front) begin
      data_next = (IDX == 0) ? cmd.value : left_data;
    end else if (cmd.push_back) begin
      if (MY_IDX == count) data_next = cmd.value;
    end else if (cmd.pop_front) begin
      data_next = right_data;
    end else if (cmd.rotate) begin
      // occupied part rotates left, front wraps to the back slot
      if (MY_IDX == count_m1) data_next = wrap_data;
      else if (MY_IDX < count_m1) data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

// File: rtl/double_ended_queue_top.sv
// Double-ended queue top level: request decode, cell row and result register.
// Push and pop requests never raise busy; result strobed the cycle after acceptance.
// Dump of N entries: busy until the last entry is listed, one result per cycle, the row rotating
// one slot per cycle through the cell chain; empty dump gives one result.
// Results cannot be stalled; each is valid for the single cycle done is high.
// Synchronous reset empties the queue; cell contents are left as they were.
module double_ended_queue_top #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF,
  parameter int OCC_W = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [dq_pkg::FUNC_W-1:0]   func,
  input  logic signed [dq_pkg::DATA_W-1:0] value,
  output logic                        done,
  output logic [dq_pkg::STATUS_W-1:0] status,
  output logic signed [dq_pkg::DATA_W-1:0] item_value,
  output logic                        last,
  output logic [OCC_W-1:0]            occupancy
);
  import dq_pkg::*;

  localparam logic [OCC_W-1:0] FULL_CNT = OCC_W'(DEPTH);

  // Control state
  state_t           state, state_next;
  logic [OCC_W-1:0] count, count_next;
  logic [OCC_W-1:0] dump_cnt, dump_cnt_next;

  // Cell row
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] back_data;
  logic [OCC_W-1:0]  count_m1;

  // Result register inputs
  logic              done_next;
  logic [STATUS_W-1:0] status_next;
  logic [DATA_W-1:0] item_next;
  logic              last_next;

  logic accept, is_empty, is_full;

  assign accept   = start && (state == S_IDLE);
  assign is_empty = (count == '0);
  assign is_full  = (count == FULL_CNT);
  assign count_m1 = count - OCC_W'(1);
  assign busy     = (state == S_DUMP);

  // Back entry select for pop back: one-hot compare across the row.
  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (count_m1 == OCC_W'(i)) back_data = back_data | cell_data[i];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && func == FN_DUMP && !is_empty) state_next = S_DUMP;
      end
      S_DUMP: begin
        if (dump_cnt == count_m1) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: cell command, count and result
  always_comb begin
    cmd           = '0;
    cmd.value     = value;
    count_next    = count;
    dump_cnt_next = dump_cnt;
    done_next     = 1'b0;
    status_next   = ST_OK;
    item_next     = '0;
    last_next     = 1'b1;
    unique case (state)
      S_IDLE: begin
        dump_cnt_next = '0;
        if (accept) begin
          unique case (func)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
              done_next = 1'b1;
              item_next = value;
              if (is_full) begin
                status_next = ST_FULL;
              end else begin
                cmd.push_front = (func == FN_PUSH_FRONT);
                cmd.push_back  = (func == FN_PUSH_BACK);
                count_next     = count + OCC_W'(1);
              end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
              done_next = 1'b1;
              if (is_empty) begin
                status_next = ST_EMPTY;
              end else begin
                item_next     = (func == FN_POP_FRONT) ? cell_data[0] : back_data;
                cmd.pop_front = (func == FN_POP_FRONT);
                count_next    = count_m1;
              end
            end
            FN_DUMP: begin
              // nonempty dump starts listing next cycle
              if (is_empty) begin
                done_next   = 1'b1;
                status_next = ST_EMPTY;
              end
            end
            default: ;  // unused codes: no result, no change
          endcase
        end
      end
      S_DUMP: begin
        done_next     = 1'b1;
        item_next     = cell_data[0];
        last_next     = (dump_cnt == count_m1);
        cmd.rotate    = 1'b1;
        dump_cnt_next = dump_cnt + OCC_W'(1);
      end
      default: ;
    endcase
  end

  // Cell row; neighbors hand data left or right when a shift is commanded.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_W-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = cell_data[g];
    end else begin : g_mid
      assign left_d = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_lastc
      assign right_d = cell_data[g];
    end else begin : g_notlast
      assign right_d = cell_data[g+1];
    end
    dq_cell #(
      .DEPTH (DEPTH),
      .IDX   (g),
      .CNT_W (OCC_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .left_data  (left_d),
      .right_data (right_d),
      .wrap_data  (cell_data[0]),
      .data       (cell_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      dump_cnt <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dump_cnt <= dump_cnt_next;
      done     <= done_next;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    status     <= status_next;
    item_value <= item_next;
    last       <= last_next;
    occupancy  <= count_next;
  end

  // Dump only runs on a nonempty queue.
  a_dump_nonempty: assert property (@(posedge clk) disable iff (rst)
    busy |-> count != '0)
    else $error("dump running on empty queue");

  // Leaving dump coincides with the final listed entry.
  a_dump_ends_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done && last)
    else $error("dump ended without marking last entry");

  // A full report only comes with a full queue.
  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> occupancy == FULL_CNT)
    else $error("full status with queue not full");

  // Popping the front of an empty queue reports empty on the next cycle.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    start && !busy && count == '0 && func == FN_POP_FRONT
      |=> done && status == ST_EMPTY)
    else $error("pop of empty queue not reported");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the double-ended queue: directed corners, then random bursts.
module testbench;
  import dq_pkg::*;

  localparam int DEPTH          = DEPTH_DEF;
  localparam int OCC_W          = $clog2(DEPTH + 1);
  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_REQS    = 130;
  // Slowest legal run is roughly 170 requests, each a full dump of 16 results
  // after the longest idle gap; the limit gives about fifteen times that.
  localparam int TIMEOUT_CYCLES = 150000;

  // Codes the block decodes as no-ops.
  localparam logic [FUNC_W-1:0] FN_FIRST_UNUSED = 3'd5;
  localparam logic [FUNC_W-1:0] FN_LAST_UNUSED  = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  // Burst flavors for the random part: lean toward pushes, pops, or neither.
  typedef enum int {
    BURST_FILL,
    BURST_DRAIN,
    BURST_MIXED
  } burst_kind_t;

  typedef struct {
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] value;
    int                       gap;    // idle cycles before this request is raised
  } deque_request_t;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] item_value;
    logic                     last;
    logic [OCC_W-1:0]         occupancy;
  } deque_result_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [FUNC_W-1:0]           func = '0;
  logic signed [DATA_W-1:0]    value = '0;
  logic                        done;
  logic [STATUS_W-1:0]         status;
  logic signed [DATA_W-1:0]    item_value;
  logic                        last;
  logic [OCC_W-1:0]            occupancy;

  double_ended_queue_top #(.DEPTH(DEPTH)) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .value      (value),
    .done       (done),
    .status     (status),
    .item_value (item_value),
    .last       (last),
    .occupancy  (occupancy)
  );

  // Requests waiting to be driven, and results the shadow deque says must come.
  deque_request_t pending_requests[$];
  deque_result_t  expected_results[$];

  // Shadow deque: ring storage, front slot and entry count.
  logic signed [DATA_W-1:0] shadow_ring[DEPTH];
  int                       shadow_front = 0;
  int                       shadow_count = 0;

  // Bookkeeping for the closing summary.
  int error_count    = 0;
  int accepted_reqs  = 0;
  int ignored_reqs   = 0;
  int push_reqs      = 0;
  int pop_reqs       = 0;
  int dump_reqs      = 0;
  int full_rejects   = 0;
  int empty_replies  = 0;
  int longest_dump   = 0;
  int checked_results = 0;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic queue_result(input status_t st, input logic signed [DATA_W-1:0] v,
                              input logic lst);
    deque_result_t r;
    r.status     = st;
    r.item_value = v;
    r.last       = lst;
    r.occupancy  = OCC_W'(shadow_count);
    expected_results.push_back(r);
  endtask

  // Apply one accepted request to the shadow deque and queue what it must produce.
  task automatic apply_to_shadow_deque(input logic [FUNC_W-1:0] op,
                                       input logic signed [DATA_W-1:0] v);
    int slot;
    int i;
    case (op)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        push_reqs++;
        if (shadow_count >= DEPTH) begin
          // Full: value echoed, nothing stored.
          full_rejects++;
          queue_result(ST_FULL, v, 1'b1);
        end else begin
          if (op == FN_PUSH_FRONT) begin
            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
            slot = shadow_front;
          end else begin
            slot = (shadow_front + shadow_count) % DEPTH;
          end
          shadow_ring[slot] = v;
          shadow_count++;
          queue_result(ST_OK, v, 1'b1);
        end
      end
      FN_POP_FRONT, FN_POP_BACK: begin
        pop_reqs++;
        if (shadow_count == 0) begin
          empty_replies++;
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          if (op == FN_POP_FRONT) begin
            slot = shadow_front;
            shadow_front = (shadow_front + 1) % DEPTH;
          end else begin
            slot = (shadow_front + shadow_count - 1) % DEPTH;
          end
          shadow_count--;
          queue_result(ST_OK, shadow_ring[slot], 1'b1);
        end
      end
      FN_DUMP: begin
        dump_reqs++;
        if (shadow_count == 0) begin
          empty_replies++;
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          // Front to back, contents untouched, last on the final entry.
          for (i = 0; i < shadow_count; i++) begin
            slot = (shadow_front + i) % DEPTH;
            queue_result(ST_OK, shadow_ring[slot], (i == shadow_count - 1));
          end
          if (shadow_count > longest_dump) longest_dump = shadow_count;
        end
      end
      default: ignored_reqs++;  // unused code: no result, no state change
    endcase
  endtask

  // Idle length before a request: mostly back-to-back, a few long pauses.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return -1;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_request(input logic [FUNC_W-1:0] op,
                             input logic signed [DATA_W-1:0] v, input int gap);
    deque_request_t q;
    q.func  = op;
    q.value = v;
    q.gap   = gap;
    pending_requests.push_back(q);
  endtask

  // Driver: raises start for the head of the pending list and holds it until
  // the block takes it (start high, busy low at the edge). The shadow deque is
  // updated at that same edge from the values on the ports.
  deque_request_t next_req;
  int             idle_cycles = 0;

  always @(posedge clk) begin
    if (rst) begin
      start       <= 1'b0;
      idle_cycles <= 0;
    end else if (start && !busy) begin
      apply_to_shadow_deque(func, value);
      accepted_reqs++;
      if (pending_requests.size() > 0 && pending_requests[0].gap == 0) begin
        // Back-to-back: start stays high, new payload.
        next_req = pending_requests.pop_front();
        func  <= next_req.func;
        value <= next_req.value;
      end else begin
        start       <= 1'b0;
        idle_cycles <= 1;
      end
    end else if (!start && pending_requests.size() > 0) begin
      if (idle_cycles < pending_requests[0].gap) begin
        idle_cycles <= idle_cycles + 1;
      end else begin
        next_req = pending_requests.pop_front();
        func        <= next_req.func;
        value       <= next_req.value;
        start       <= 1'b1;
        idle_cycles <= 0;
      end
    end
  end

  // Monitor: every done cycle is one result; it must match the oldest expectation.
  deque_result_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d item_value %0d last %0b occupancy %0d",
               status, item_value, last, occupancy);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        checked_results++;
        if (status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, status);
          error_count++;
        end
        if (item_value !== want.item_value) begin
          $error("item_value mismatch: expected %0d, actual %0d",
                 want.item_value, item_value);
          error_count++;
        end
        if (last !== want.last) begin
          $error("last mismatch: expected %0b, actual %0b", want.last, last);
          error_count++;
        end
        if (occupancy !== want.occupancy) begin
          $error("occupancy mismatch: expected %0d, actual %0d",
                 want.occupancy, occupancy);
          error_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int          random_reqs;
    int          burst_len;
    int          push_pct;
    int          r;
    int          n;
    bit          quiet;
    burst_kind_t kind;
    logic [FUNC_W-1:0] op;

    random_reqs = 0;

    // Directed: empty-queue corners and an ignored code first.
    add_request(FN_POP_FRONT, 32'sh1234_5678, 0);
    add_request(FN_POP_BACK, -1, 1);
    add_request(FN_DUMP, '0, 0);
    add_request(FN_FIRST_UNUSED, VAL_MAX, 0);
    // Fill to DEPTH from both ends; value extremes go in first.
    for (n = 0; n < DEPTH; n++) begin
      case (n)
        0:       add_request(FN_PUSH_FRONT, VAL_MAX, 0);
        1:       add_request(FN_PUSH_BACK, VAL_MIN, 0);
        2:       add_request(FN_PUSH_FRONT, -1, 2);
        3:       add_request(FN_PUSH_BACK, '0, 0);
        default: add_request((n % 2) ? FN_PUSH_BACK : FN_PUSH_FRONT, $urandom(), pick_gap());
      endcase
    end
    // Full rejects at both ends, a full dump, a pop from each end, then an ignored code.
    add_request(FN_PUSH_FRONT, 32'sh5555_5555, 0);
    add_request(FN_PUSH_BACK, 32'shAAAA_AAAA, 0);
    add_request(FN_DUMP, '0, 0);
    add_request(FN_POP_FRONT, '0, 0);
    add_request(FN_POP_BACK, VAL_MIN, 3);
    add_request(FN_LAST_UNUSED, '0, 0);

    // Random bursts: fill and drain phases swing occupancy between empty and
    // full so the ring wraps; some bursts run with no idle cycles at all.
    while (random_reqs < RANDOM_REQS) begin
      kind      = burst_kind_t'($urandom_range(0, 2));
      quiet     = ($urandom_range(0, 4) == 0);
      burst_len = $urandom_range(8, 24);
      case (kind)
        BURST_FILL:  push_pct = 75;
        BURST_DRAIN: push_pct = 25;
        default:     push_pct = 50;
      endcase
      for (n = 0; n < burst_len; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          op = FUNC_W'($urandom_range(FN_FIRST_UNUSED, FN_LAST_UNUSED));
        end else begin
          random_reqs++;
          if (r < 11) op = FN_DUMP;
          else if ($urandom_range(0, 99) < push_pct)
            op = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
          else
            op = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
        end
        add_request(op, pick_value(), quiet ? 0 : pick_gap());
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Every request taken, every expected result seen, then a dump's worth of
    // quiet cycles to catch any stray strobe.
    while (pending_requests.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    $display("Run covered %0d requests (%0d push, %0d pop, %0d dump, %0d ignored), %0d results",
             accepted_reqs, push_reqs, pop_reqs, dump_reqs, ignored_reqs, checked_results);
    $display("Full rejects %0d, empty replies %0d, longest dump %0d entries, errors %0d",
             full_rejects, empty_replies, longest_dump, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
